// ===== rtl/core/tapq_pkg.sv =====
package tapq_pkg;

	// Fixed values of the attestation structure.
	localparam logic [31:0] MAGIC_WORD      = 32'hff544347;
	localparam logic [15:0] QUOTE_TYPE      = 16'h8018;
	localparam logic [15:0] MAGIC_BYTES     = 16'd4;
	localparam logic [15:0] SHORT_BYTES     = 16'd2;
	localparam logic [15:0] SEL_COUNT_BYTES = 16'd4;
	localparam logic [15:0] SEL_SIZE_BYTES  = 16'd1;
	localparam logic [15:0] CLOCK_BYTES     = 16'd17;
	localparam logic [15:0] FW_BYTES        = 16'd8;

	// Default depth of the result queue; it must hold at least two results.
	localparam int RES_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_EXTRA  = 2'd0,
		KIND_DIGEST = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PH_MAGIC,
		PH_TYPE,
		PH_SIGNER_LEN,
		PH_SIGNER,
		PH_EXTRA_LEN,
		PH_EXTRA,
		PH_CLOCK,
		PH_FW,
		PH_SEL_COUNT,
		PH_SEL_HASH,
		PH_SEL_SIZE,
		PH_SEL_BITS,
		PH_DIGEST_LEN,
		PH_DIGEST,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [7:0]  out_byte;
		logic        out_last;
		logic        parse_ok;
		logic        is_quote;
		logic [15:0] extra_len;
		logic [15:0] digest_len;
	} res_item_t;

	// Results produced by one byte: an optional data byte, then an optional status.
	typedef struct packed {
		logic      data_vld;
		res_item_t data;
		logic      stat_vld;
		res_item_t stat;
	} push_t;

endpackage

// ===== rtl/core/tapq_parser.sv =====
module tapq_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_vld,
	input  tapq_pkg::in_item_t item,
	output tapq_pkg::push_t    push
);

	tapq_pkg::phase_t phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] sel_q, sel_d;
	logic [15:0] type_q, type_d;
	logic [15:0] extra_q, extra_d;
	logic [15:0] digest_q, digest_d;
	logic        err_q, err_d;

	logic [31:0] acc_shift;
	logic [15:0] cnt_dec;
	logic [15:0] n16;
	logic [31:0] sel_dec;
	logic        active;
	logic        is_quote_d;

	assign acc_shift = {acc_q[23:0], item.in_byte};
	assign cnt_dec   = cnt_q - 16'd1;
	assign n16       = acc_shift[15:0];
	assign sel_dec   = sel_q - 32'd1;
	assign active    = (phase_q != tapq_pkg::PH_DONE) && (phase_q != tapq_pkg::PH_ERROR);

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		acc_d    = acc_q;
		sel_d    = sel_q;
		type_d   = type_q;
		extra_d  = extra_q;
		digest_d = digest_q;
		err_d    = err_q;
		if (active) begin
			acc_d = acc_shift;
			cnt_d = cnt_dec;
			if (cnt_dec == 16'd0) begin
				acc_d = '0;
				case (phase_q)
					tapq_pkg::PH_MAGIC: begin
						if (acc_shift == tapq_pkg::MAGIC_WORD) begin
							phase_d = tapq_pkg::PH_TYPE;
							cnt_d   = tapq_pkg::SHORT_BYTES;
						end else begin
							err_d   = 1'b1;
							phase_d = tapq_pkg::PH_ERROR;
							cnt_d   = '0;
						end
					end
					tapq_pkg::PH_TYPE: begin
						type_d  = n16;
						phase_d = tapq_pkg::PH_SIGNER_LEN;
						cnt_d   = tapq_pkg::SHORT_BYTES;
					end
					tapq_pkg::PH_SIGNER_LEN: begin
						if (n16 != 16'd0) begin
							phase_d = tapq_pkg::PH_SIGNER;
							cnt_d   = n16;
						end else begin
							phase_d = tapq_pkg::PH_EXTRA_LEN;
							cnt_d   = tapq_pkg::SHORT_BYTES;
						end
					end
					tapq_pkg::PH_SIGNER: begin
						phase_d = tapq_pkg::PH_EXTRA_LEN;
						cnt_d   = tapq_pkg::SHORT_BYTES;
					end
					tapq_pkg::PH_EXTRA_LEN: begin
						extra_d = n16;
						if (n16 != 16'd0) begin
							phase_d = tapq_pkg::PH_EXTRA;
							cnt_d   = n16;
						end else begin
							phase_d = tapq_pkg::PH_CLOCK;
							cnt_d   = tapq_pkg::CLOCK_BYTES;
						end
					end
					tapq_pkg::PH_EXTRA: begin
						phase_d = tapq_pkg::PH_CLOCK;
						cnt_d   = tapq_pkg::CLOCK_BYTES;
					end
					tapq_pkg::PH_CLOCK: begin
						phase_d = tapq_pkg::PH_FW;
						cnt_d   = tapq_pkg::FW_BYTES;
					end
					tapq_pkg::PH_FW: begin
						if (type_q == tapq_pkg::QUOTE_TYPE) begin
							phase_d = tapq_pkg::PH_SEL_COUNT;
							cnt_d   = tapq_pkg::SEL_COUNT_BYTES;
						end else begin
							phase_d = tapq_pkg::PH_DONE;
							cnt_d   = '0;
						end
					end
					tapq_pkg::PH_SEL_HASH: begin
						phase_d = tapq_pkg::PH_SEL_SIZE;
						cnt_d   = tapq_pkg::SEL_SIZE_BYTES;
					end
					tapq_pkg::PH_SEL_COUNT, tapq_pkg::PH_SEL_SIZE,
					tapq_pkg::PH_SEL_BITS: begin
						if (phase_q == tapq_pkg::PH_SEL_SIZE && acc_shift[7:0] != 8'd0) begin
							phase_d = tapq_pkg::PH_SEL_BITS;
							cnt_d   = {8'd0, acc_shift[7:0]};
						end else begin
							// A selection count loads the counter; a finished selection
							// counts it down. Either way the list then continues or ends.
							sel_d = (phase_q == tapq_pkg::PH_SEL_COUNT) ? acc_shift : sel_dec;
							if (sel_d == 32'd0) begin
								phase_d = tapq_pkg::PH_DIGEST_LEN;
								cnt_d   = tapq_pkg::SHORT_BYTES;
							end else begin
								phase_d = tapq_pkg::PH_SEL_HASH;
								cnt_d   = tapq_pkg::SHORT_BYTES;
							end
						end
					end
					tapq_pkg::PH_DIGEST_LEN: begin
						digest_d = n16;
						if (n16 != 16'd0) begin
							phase_d = tapq_pkg::PH_DIGEST;
							cnt_d   = n16;
						end else begin
							phase_d = tapq_pkg::PH_DONE;
							cnt_d   = '0;
						end
					end
					tapq_pkg::PH_DIGEST: begin
						phase_d = tapq_pkg::PH_DONE;
						cnt_d   = '0;
					end
					default: begin
						phase_d = tapq_pkg::PH_ERROR;
						cnt_d   = '0;
					end
				endcase
			end
		end
	end

	assign is_quote_d = (type_d == tapq_pkg::QUOTE_TYPE);

	always_comb begin
		push = '0;
		push.data_vld      = byte_vld && active &&
			((phase_q == tapq_pkg::PH_EXTRA) || (phase_q == tapq_pkg::PH_DIGEST));
		push.data.out_kind = (phase_q == tapq_pkg::PH_EXTRA) ? tapq_pkg::KIND_EXTRA
			: tapq_pkg::KIND_DIGEST;
		push.data.out_byte = item.in_byte;
		push.stat_vld        = byte_vld && item.in_last;
		push.stat.out_kind   = tapq_pkg::KIND_STATUS;
		push.stat.out_last   = 1'b1;
		push.stat.parse_ok   = (phase_d == tapq_pkg::PH_DONE) && !err_d;
		push.stat.is_quote   = is_quote_d;
		push.stat.extra_len  = extra_d;
		push.stat.digest_len = is_quote_d ? digest_d : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tapq_pkg::PH_MAGIC;
			cnt_q    <= tapq_pkg::MAGIC_BYTES;
			acc_q    <= '0;
			sel_q    <= '0;
			type_q   <= '0;
			extra_q  <= '0;
			digest_q <= '0;
			err_q    <= 1'b0;
		end else if (byte_vld) begin
			if (item.in_last) begin
				phase_q  <= tapq_pkg::PH_MAGIC;
				cnt_q    <= tapq_pkg::MAGIC_BYTES;
				acc_q    <= '0;
				sel_q    <= '0;
				type_q   <= '0;
				extra_q  <= '0;
				digest_q <= '0;
				err_q    <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				cnt_q    <= cnt_d;
				acc_q    <= acc_d;
				sel_q    <= sel_d;
				type_q   <= type_d;
				extra_q  <= extra_d;
				digest_q <= digest_d;
				err_q    <= err_d;
			end
		end
	end

endmodule

// ===== rtl/core/tapq_result_fifo.sv =====
module tapq_result_fifo #(
	parameter int DEPTH = tapq_pkg::RES_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tapq_pkg::push_t     push,
	output logic                room2,
	output logic                res_valid,
	input  logic                res_stall,
	output tapq_pkg::res_item_t res_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tapq_pkg::res_item_t mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr_nxt;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [1:0]    npush;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_nxt    = inc(wr_q);
	assign res_valid = (count_q != '0);
	assign res_item  = mem[rd_q];
	assign pop       = res_valid && !res_stall;
	assign npush     = {1'b0, push.data_vld} + {1'b0, push.stat_vld};
	assign room2     = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.data_vld) begin
			mem[wr_q] <= push.data;
			if (push.stat_vld) begin
				mem[wr_nxt] <= push.stat;
			end
		end else if (push.stat_vld) begin
			mem[wr_q] <= push.stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			case (npush)
				2'd1:    wr_q <= wr_nxt;
				2'd2:    wr_q <= inc(wr_nxt);
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= inc(rd_q);
			end
			count_q <= count_q + CW'(npush) - CW'(pop);
		end
	end

endmodule

// ===== rtl/core/tpm_attest_quote_parser_core.sv =====
// A byte is held in the input register, then parsed as its results enter the result queue.
// A final byte that also carries a data byte queues its status behind the data result.
// One byte per cycle while the queue has room; a status result takes one more slot on the output.
// The result queue sets the rate: a byte enters the parser only when two slots are free.
// Reset (arst_n low, asynchronous) returns the parser to the magic-word phase and empties the queue.
module tpm_attest_quote_parser_core #(
	parameter int RES_DEPTH = tapq_pkg::RES_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  tapq_pkg::in_item_t  src_item,
	output logic                res_valid,
	input  logic                res_stall,
	output tapq_pkg::res_item_t res_item
);

	// The input register holds one byte in front of the parser. It advances whenever the
	// result queue has room for the two results a single byte can cause (a data byte and,
	// on the final byte of a buffer, the status), so the parser never has to back up.
	logic               vld_s1;
	tapq_pkg::in_item_t item_s1;
	logic               room2;
	logic               adv_s1;
	tapq_pkg::push_t    push;

	assign adv_s1    = vld_s1 && room2;
	assign src_stall = vld_s1 && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!src_stall) begin
			vld_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

	// The parser walks the structure field by field. Data bytes inside extraData and the
	// PCR digest are passed through; the final byte of a buffer adds a status result and
	// brings the parser back to its starting phase.
	tapq_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_vld (adv_s1),
		.item     (item_s1),
		.push     (push)
	);

	// The result queue is the output register: a waiting result never blocks a new byte
	// as long as two slots remain free.
	tapq_result_fifo #(
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	// A final byte that enters the parser always produces a status result.
	a_last_gives_status: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.in_last) |-> push.stat_vld)
		else $error("final byte produced no status");

	// A passed-through byte is never tagged as a status.
	a_data_kind: assert property (@(posedge clk) disable iff (!arst_n)
		push.data_vld |-> (push.data.out_kind != tapq_pkg::KIND_STATUS))
		else $error("data result tagged as status");

	// Back pressure on the input only ever comes from a held byte.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> vld_s1)
		else $error("input stalled with empty input register");

	// Only status results carry the last mark.
	a_last_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.out_last == (res_item.out_kind == tapq_pkg::KIND_STATUS)))
		else $error("last mark does not match result kind");

endmodule

// ===== test/tb_tpm_attest_quote_parser_core.sv =====
`timescale 1ns / 100ps

module tb_tpm_attest_quote_parser_core;

	// Random frames stop once this many bytes have been parsed, not counting ignored bytes.
	localparam int RANDOM_BYTES  = 120;
	// Declared extraData and digest lengths above this cap are sent only partly, which
	// ends the frame early.
	localparam int DATA_CAP      = 24;
	// The receiver holds off this many cycles while the sender keeps offering bytes.
	localparam int BACKLOG_HOLD  = 300;
	localparam int DRAIN_LIMIT   = 5000;
	// Lets trailing bytes that cause no result pass the input register and the parser, with margin.
	localparam int SETTLE_CYCLES = 8;
	localparam int RUN_LIMIT_NS  = 6_000_000;
	localparam int PRINT_LIMIT   = 30;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                src_valid = 1'b0;
	logic                src_stall;
	tapq_pkg::in_item_t  src_item  = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	tapq_pkg::res_item_t res_item;

	tpm_attest_quote_parser_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Results the parser owes us, oldest first, and the byte image of the frame being sent.
	tapq_pkg::res_item_t attest_out_q[$];
	logic [7:0]          frame_q[$];

	int error_count   = 0;
	int results_seen  = 0;
	int bytes_parsed  = 0;
	int hold_request  = 0;
	bit tx_gaps_on    = 1'b1;
	bit rx_gaps_on    = 1'b1;

	// Shadow copy of the parser state, advanced once per accepted byte.
	tapq_pkg::phase_t sh_phase;
	logic [15:0]      sh_left;
	logic [31:0]      sh_accum;
	logic [31:0]      sh_sels;
	logic [15:0]      sh_type;
	logic [15:0]      sh_extra_len;
	logic [15:0]      sh_digest_len;
	logic             sh_bad_magic;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (error_count < PRINT_LIMIT)
			$display("%0t: result %0d: %s: got %0h, want %0h", $realtime, results_seen,
				what, got, want);
		error_count++;
	endtask

	function automatic void clear_shadow();
		sh_phase      = tapq_pkg::PH_MAGIC;
		sh_left       = tapq_pkg::MAGIC_BYTES;
		sh_accum      = '0;
		sh_sels       = '0;
		sh_type       = '0;
		sh_extra_len  = '0;
		sh_digest_len = '0;
		sh_bad_magic  = 1'b0;
	endfunction

	function automatic void start_field(tapq_pkg::phase_t ph, logic [15:0] count);
		sh_phase = ph;
		sh_left  = count;
		sh_accum = '0;
	endfunction

	// After a selection count or a finished selection, the list continues or ends.
	function automatic void next_selection();
		if (sh_sels == 32'd0) start_field(tapq_pkg::PH_DIGEST_LEN, tapq_pkg::SHORT_BYTES);
		else start_field(tapq_pkg::PH_SEL_HASH, tapq_pkg::SHORT_BYTES);
	endfunction

	// Works out the results that one accepted byte causes and queues them.
	// A data result is tagged by the phase the byte arrives in, while the status
	// that a final byte adds reflects the phase after that byte is consumed.
	function automatic void parse_attest_byte(tapq_pkg::in_item_t it);
		tapq_pkg::res_item_t r;
		logic [15:0] n16;
		if (sh_phase < tapq_pkg::PH_DONE) begin
			bytes_parsed++;
			if (sh_phase == tapq_pkg::PH_EXTRA || sh_phase == tapq_pkg::PH_DIGEST) begin
				r = '0;
				r.out_kind = (sh_phase == tapq_pkg::PH_EXTRA) ? tapq_pkg::KIND_EXTRA
					: tapq_pkg::KIND_DIGEST;
				r.out_byte = it.in_byte;
				attest_out_q.push_back(r);
			end
			sh_accum = {sh_accum[23:0], it.in_byte};
			sh_left  = sh_left - 16'd1;
			if (sh_left == 16'd0) begin
				n16 = sh_accum[15:0];
				case (sh_phase)
				tapq_pkg::PH_MAGIC: begin
					if (sh_accum == tapq_pkg::MAGIC_WORD) begin
						start_field(tapq_pkg::PH_TYPE, tapq_pkg::SHORT_BYTES);
					end else begin
						// A wrong magic word poisons the rest of the frame.
						sh_bad_magic = 1'b1;
						start_field(tapq_pkg::PH_ERROR, 16'd0);
					end
				end
				tapq_pkg::PH_TYPE: begin
					sh_type = n16;
					start_field(tapq_pkg::PH_SIGNER_LEN, tapq_pkg::SHORT_BYTES);
				end
				tapq_pkg::PH_SIGNER_LEN: begin
					if (n16 != 16'd0) start_field(tapq_pkg::PH_SIGNER, n16);
					else start_field(tapq_pkg::PH_EXTRA_LEN, tapq_pkg::SHORT_BYTES);
				end
				tapq_pkg::PH_SIGNER: start_field(tapq_pkg::PH_EXTRA_LEN, tapq_pkg::SHORT_BYTES);
				tapq_pkg::PH_EXTRA_LEN: begin
					sh_extra_len = n16;
					if (n16 != 16'd0) start_field(tapq_pkg::PH_EXTRA, n16);
					else start_field(tapq_pkg::PH_CLOCK, tapq_pkg::CLOCK_BYTES);
				end
				tapq_pkg::PH_EXTRA: start_field(tapq_pkg::PH_CLOCK, tapq_pkg::CLOCK_BYTES);
				tapq_pkg::PH_CLOCK: start_field(tapq_pkg::PH_FW, tapq_pkg::FW_BYTES);
				tapq_pkg::PH_FW: begin
					if (sh_type == tapq_pkg::QUOTE_TYPE)
						start_field(tapq_pkg::PH_SEL_COUNT, tapq_pkg::SEL_COUNT_BYTES);
					else start_field(tapq_pkg::PH_DONE, 16'd0);
				end
				tapq_pkg::PH_SEL_COUNT: begin
					sh_sels = sh_accum;
					next_selection();
				end
				tapq_pkg::PH_SEL_HASH:
					start_field(tapq_pkg::PH_SEL_SIZE, tapq_pkg::SEL_SIZE_BYTES);
				tapq_pkg::PH_SEL_SIZE: begin
					if (sh_accum[7:0] != 8'd0) begin
						start_field(tapq_pkg::PH_SEL_BITS, {8'd0, sh_accum[7:0]});
					end else begin
						sh_sels = sh_sels - 32'd1;
						next_selection();
					end
				end
				tapq_pkg::PH_SEL_BITS: begin
					sh_sels = sh_sels - 32'd1;
					next_selection();
				end
				tapq_pkg::PH_DIGEST_LEN: begin
					sh_digest_len = n16;
					if (n16 != 16'd0) start_field(tapq_pkg::PH_DIGEST, n16);
					else start_field(tapq_pkg::PH_DONE, 16'd0);
				end
				tapq_pkg::PH_DIGEST: start_field(tapq_pkg::PH_DONE, 16'd0);
				default: ;
				endcase
			end
		end
		if (it.in_last) begin
			r = '0;
			r.out_kind   = tapq_pkg::KIND_STATUS;
			r.out_last   = 1'b1;
			r.parse_ok   = (sh_phase == tapq_pkg::PH_DONE) && !sh_bad_magic;
			r.is_quote   = (sh_type == tapq_pkg::QUOTE_TYPE);
			r.extra_len  = sh_extra_len;
			r.digest_len = r.is_quote ? sh_digest_len : 16'd0;
			attest_out_q.push_back(r);
			clear_shadow();
		end
	endfunction

	task automatic check_result(tapq_pkg::res_item_t got);
		tapq_pkg::res_item_t want;
		results_seen++;
		if (attest_out_q.size() == 0) begin
			report_mismatch("result with none pending, out_kind", got.out_kind, 0);
			return;
		end
		want = attest_out_q.pop_front();
		if (got.out_kind !== want.out_kind)
			report_mismatch("out_kind", got.out_kind, want.out_kind);
		if (got.out_byte !== want.out_byte)
			report_mismatch("out_byte", got.out_byte, want.out_byte);
		if (got.out_last !== want.out_last)
			report_mismatch("out_last", got.out_last, want.out_last);
		if (got.parse_ok !== want.parse_ok)
			report_mismatch("parse_ok", got.parse_ok, want.parse_ok);
		if (got.is_quote !== want.is_quote)
			report_mismatch("is_quote", got.is_quote, want.is_quote);
		if (got.extra_len !== want.extra_len)
			report_mismatch("extra_len", got.extra_len, want.extra_len);
		if (got.digest_len !== want.digest_len)
			report_mismatch("digest_len", got.digest_len, want.digest_len);
	endtask

	// Offers one byte and waits for its transfer. Stall is sampled at the falling
	// edge, when everything has settled, and the transfer happens at the next rising
	// edge. Valid only drops across a gap, so it never gets two updates in one step.
	task automatic send_byte(logic [7:0] data, logic is_last);
		int gap;
		int r;
		bit taken;
		tapq_pkg::in_item_t it;
		gap = 0;
		if (tx_gaps_on) begin
			r = $urandom_range(99);
			gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(3, 1) : $urandom_range(30, 10);
		end
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.in_byte = data;
		it.in_last = is_last;
		src_valid <= 1'b1;
		src_item  <= it;
		do begin
			@(negedge clk);
			taken = !src_stall;
			@(posedge clk);
		end while (!taken);
		parse_attest_byte(it);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	// Stops offering bytes and waits until every owed result has transferred, then
	// lets the pipeline settle, since trailing ignored bytes cause no result.
	task automatic drain_results();
		int waited;
		src_valid <= 1'b0;
		waited = 0;
		while (attest_out_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (attest_out_q.size() != 0) begin
			report_mismatch("results never delivered", attest_out_q.size(), 0);
			attest_out_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_be(logic [31:0] v, int n);
		for (int i = n - 1; i >= 0; i--)
			frame_q.push_back(v[8*i +: 8]);
	endfunction

	function automatic void push_random(int n);
		for (int i = 0; i < n; i++)
			frame_q.push_back($urandom_range(255));
	endfunction

	// Builds a big-endian attestation image. Selections and digest are only laid
	// out for the quote type; at most eight selections are written whatever the
	// declared count says.
	task automatic build_attest(logic [31:0] magic, logic [15:0] atype, int signer_len,
		int extra_len, logic [31:0] sel_count, int size_min, int size_max, int digest_len);
		int sz;
		frame_q.delete();
		push_be(magic, 4);
		push_be(atype, 2);
		push_be(signer_len, 2);
		push_random(signer_len);
		push_be(extra_len, 2);
		push_random((extra_len < DATA_CAP) ? extra_len : DATA_CAP);
		push_random(tapq_pkg::CLOCK_BYTES + tapq_pkg::FW_BYTES);
		if (atype == tapq_pkg::QUOTE_TYPE) begin
			push_be(sel_count, 4);
			for (int s = 0; s < sel_count && s < 8; s++) begin
				sz = $urandom_range(size_max, size_min);
				push_be($urandom_range(16'hffff), 2);
				push_be(sz, 1);
				push_random(sz);
			end
			push_be(digest_len, 2);
			push_random((digest_len < DATA_CAP) ? digest_len : DATA_CAP);
		end
	endtask

	// A final byte straight after reset, and another right after it, each end an empty frame.
	task automatic test_lone_last();
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		drain_results();
	endtask

	// One flipped bit in each byte of the magic word, and an all-zero word. Bytes
	// after a wrong magic word are ignored, so a short tail is enough.
	task automatic test_bad_magic();
		for (int k = 0; k < 4; k++) begin
			build_attest(tapq_pkg::MAGIC_WORD ^ (32'h1 << (8 * k + $urandom_range(7))),
				tapq_pkg::QUOTE_TYPE, 2, 3, 1, 1, 2, 4);
			while (frame_q.size() > 8) void'(frame_q.pop_back());
			send_frame();
		end
		build_attest(32'h0, 16'h8017, 0, 2, 0, 0, 0, 0);
		send_frame();
		drain_results();
	endtask

	// A non-quote structure, complete, then again with bytes after completion.
	task automatic test_certify_attest();
		build_attest(tapq_pkg::MAGIC_WORD, 16'h8017, 6, 5, 0, 0, 0, 0);
		send_frame();
		build_attest(tapq_pkg::MAGIC_WORD, 16'h8019, 3, 2, 0, 0, 0, 0);
		repeat (5) frame_q.push_back($urandom_range(255));
		send_frame();
		drain_results();
	endtask

	// Zero-length signer, extraData, selection list and digest.
	task automatic test_zero_fields();
		build_attest(tapq_pkg::MAGIC_WORD, tapq_pkg::QUOTE_TYPE, 0, 0, 0, 0, 0, 0);
		send_frame();
		build_attest(tapq_pkg::MAGIC_WORD, 16'h8017, 0, 0, 0, 0, 0, 0);
		send_frame();
		drain_results();
	endtask

	// Quotes walking selections of size zero up to 255. The final byte is a digest
	// byte, so it yields a data result and the status together.
	task automatic test_quote_walk();
		build_attest(tapq_pkg::MAGIC_WORD, tapq_pkg::QUOTE_TYPE, 4, 6, 4, 0, 3, 8);
		send_frame();
		build_attest(tapq_pkg::MAGIC_WORD, tapq_pkg::QUOTE_TYPE, 0, 1, 1, 255, 255, 2);
		send_frame();
		drain_results();
	endtask

	// Every bit of the data byte both ways, on extraData pass-through.
	task automatic test_byte_values();
		logic [7:0] vals [8] = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f, 8'hfe};
		build_attest(tapq_pkg::MAGIC_WORD, 16'h8017, 0, 8, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++)
			frame_q[10 + i] = vals[i];
		send_frame();
		drain_results();
	endtask

	// Frames cut short at random points, and frames whose declared lengths run
	// far past the bytes actually sent.
	task automatic test_early_end();
		int keep;
		repeat (3) begin
			build_attest(tapq_pkg::MAGIC_WORD, tapq_pkg::QUOTE_TYPE, 2, 4, 2, 0, 3, 8);
			keep = $urandom_range(frame_q.size() - 1, 1);
			while (frame_q.size() > keep) void'(frame_q.pop_back());
			send_frame();
		end
		build_attest(tapq_pkg::MAGIC_WORD, 16'h8017, 0, 16'hffff, 0, 0, 0, 0);
		send_frame();
		build_attest(tapq_pkg::MAGIC_WORD, tapq_pkg::QUOTE_TYPE, 2, 3, 32'hffff_ffff, 0, 2, 4);
		send_frame();
		drain_results();
	endtask

	// The receiver holds off for a long stretch while bytes keep coming with no
	// gaps, so the result queue fills and the parser has to stall its input.
	task automatic test_result_backlog();
		tx_gaps_on = 1'b0;
		hold_request = BACKLOG_HOLD;
		build_attest(tapq_pkg::MAGIC_WORD, tapq_pkg::QUOTE_TYPE, 1, 16, 2, 1, 2, 16);
		send_frame();
		tx_gaps_on = 1'b1;
		drain_results();
	endtask

	// Mostly well-formed frames with random content, the rest bad magic words,
	// truncations, trailing bytes and plain noise, with quiet stretches mixed in.
	task automatic test_random_frames();
		int start;
		int r;
		int keep;
		logic [31:0] magic;
		logic [15:0] atype;
		start = bytes_parsed;
		while (bytes_parsed - start < RANDOM_BYTES) begin
			tx_gaps_on = ($urandom_range(4) != 0);
			rx_gaps_on = ($urandom_range(4) != 0);
			r = $urandom_range(99);
			magic = (r < 8) ? (tapq_pkg::MAGIC_WORD ^ (32'h1 << $urandom_range(31)))
				: tapq_pkg::MAGIC_WORD;
			case ($urandom_range(5))
			0: atype = 16'h8017;
			1: atype = $urandom_range(16'hffff);
			2: atype = tapq_pkg::QUOTE_TYPE ^ (16'h1 << $urandom_range(15));
			default: atype = tapq_pkg::QUOTE_TYPE;
			endcase
			build_attest(magic, atype,
				($urandom_range(2) == 0) ? 0 : $urandom_range(8),
				($urandom_range(3) == 0) ? 0 : $urandom_range(12),
				$urandom_range(3), 0, ($urandom_range(15) == 0) ? 255 : 4,
				($urandom_range(3) == 0) ? 0 : $urandom_range(20));
			if (r >= 8 && r < 22) begin
				keep = $urandom_range(frame_q.size() - 1, 1);
				while (frame_q.size() > keep) void'(frame_q.pop_back());
			end else if (r >= 22 && r < 34) begin
				repeat ($urandom_range(6, 1)) frame_q.push_back($urandom_range(255));
			end else if (r >= 34 && r < 40) begin
				frame_q.delete();
				repeat ($urandom_range(40, 1)) frame_q.push_back($urandom_range(255));
			end
			send_frame();
			if (r >= 90) drain_results();
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		drain_results();
	endtask

	// Result side: samples at the falling edge, checks each transfer at the rising
	// edge, then picks the stall for the next cycle. A long hold asked for by a
	// test is counted down here, cycle by cycle.
	initial begin : result_sink
		tapq_pkg::res_item_t got;
		bit took;
		int stall_left;
		int r;
		stall_left = 0;
		forever begin
			@(negedge clk);
			took = arst_n && res_valid && !res_stall;
			got  = res_item;
			@(posedge clk);
			if (took) check_result(got);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left != 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else if (!rx_gaps_on) begin
				res_stall <= 1'b0;
			end else begin
				r = $urandom_range(99);
				if (r < 70) begin
					res_stall <= 1'b0;
				end else begin
					res_stall <= 1'b1;
					stall_left = (r < 97) ? $urandom_range(2) : $urandom_range(40, 10);
				end
			end
		end
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("[tpm_attest_quote_parser_core] ERROR");
		$finish;
	end

	initial begin
		clear_shadow();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lone_last();
		test_bad_magic();
		test_certify_attest();
		test_zero_fields();
		test_quote_walk();
		test_byte_values();
		test_early_end();
		test_result_backlog();
		test_random_frames();
		if (error_count == 0) begin
			$display("[tpm_attest_quote_parser_core] OK");
		end else begin
			$display("[tpm_attest_quote_parser_core] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tapq_pkg.sv
rtl/core/tapq_parser.sv
rtl/core/tapq_result_fifo.sv
rtl/core/tpm_attest_quote_parser_core.sv
test/tb_tpm_attest_quote_parser_core.sv
